FILE: rtl/core/jstr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jstr_pkg;

  // Instruction count register width (holds up to 127)
  localparam int CNT_W = 7;

  // Result status codes
  localparam logic [1:0] ST_NEED   = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  // Opcode and ModRM bytes of the supported subset
  localparam logic [7:0] OP_REX_W   = 8'h48;
  localparam logic [7:0] OP_REX_WB  = 8'h49;
  localparam logic [7:0] OP_MOV_RAX = 8'hB8;
  localparam logic [7:0] OP_MOV_R10 = 8'hBA;
  localparam logic [7:0] OP_ADD_RAX = 8'h05;
  localparam logic [7:0] OP_SUB_RAX = 8'h2D;
  localparam logic [7:0] OP_XOR_RAX = 8'h35;
  localparam logic [7:0] OP_ESC     = 8'h0F;
  localparam logic [7:0] OP_IMUL    = 8'hAF;
  localparam logic [7:0] MODRM_C2   = 8'hC2;
  localparam logic [7:0] OP_JMP_REL = 8'hE9;
  localparam logic [7:0] OP_GRP5    = 8'hFF;
  localparam logic [7:0] MODRM_E0   = 8'hE0;

  // Decoder phase
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_OP1,
    PH_OP48,
    PH_OP49,
    PH_IMUL_AF,
    PH_IMUL_C2,
    PH_JMPRAX,
    PH_IMM
  } phase_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [63:0] byte_address;
    logic        begin_req;
    logic        committed;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] next_address;
    logic [63:0] target;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/jump_stub_target_resolver.sv
`timescale 1ns / 1ps
`default_nettype none

// Jump stub target resolver.
// Request channel (req_valid / req_stall / req_data): one code byte per
// request, with its address, a begin flag and the committed flag of the
// start memory. Result channel (res_valid / res_stall / res_data): one result
// per request: need-next-byte with the next fetch address, resolved with the
// target, rejected, or idle-ignored.
// A request is registered at acceptance, decoded from the input register and
// its result registered in the result register, which offers it until taken.
// One request per cycle is sustained while res_stall does not hold a result;
// the decoder steps one byte per cycle when not stalled, and the imul product
// is registered in the multiplier and then folded into rax, before any later
// byte can read rax.
// Reset clears the decoder to idle and its registers to zero, with the
// first-instruction flag set; no result is offered after reset. While
// res_stall holds a result, one more request is held in the input register
// and then req_stall rises until the result is taken.
module jump_stub_target_resolver #(
  parameter int MAX_INSTRUCTIONS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire jstr_pkg::req_t req_data,
  output logic                res_valid,
  input  wire logic           res_stall,
  output jstr_pkg::res_t      res_data
);

  logic           in_valid;
  jstr_pkg::req_t in_req;
  logic           advance;
  jstr_pkg::res_t core_res;

  assign advance   = in_valid && (!res_valid || !res_stall);
  assign req_stall = in_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!req_stall) begin
      in_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_req <= req_data;
    end
  end

  jstr_core #(
    .MAX_INSTRUCTIONS (MAX_INSTRUCTIONS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .go  (advance),
    .req (in_req),
    .res (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= core_res;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (res_valid && res_stall))
    else $error("request stalled while result register can drain");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered right after reset");

  a_done_target: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status == jstr_pkg::ST_DONE) |-> (res_data.target != 64'd0))
    else $error("resolved with zero target");

  a_target_only_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status != jstr_pkg::ST_DONE) |-> (res_data.target == 64'd0))
    else $error("target set on a non-resolved result");

endmodule

`default_nettype wire

FILE: rtl/core/jstr_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Low 64 bits of a 64x64 product: three 32x32 partial products
// are registered, then summed combinationally at the output.
module jstr_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      product
);

  logic [63:0] p_ll;
  logic [31:0] p_lh;
  logic [31:0] p_hl;
  logic [31:0] m_lh;
  logic [31:0] m_hl;
  logic [31:0] cross_sum;

  // only the low half of each cross term reaches the result
  assign m_lh = a[31:0] * b[63:32];
  assign m_hl = a[63:32] * b[31:0];

  // partial product registers
  always_ff @(posedge clk) begin
    if (start) begin
      p_ll <= a[31:0] * b[31:0];
      p_lh <= m_lh;
      p_hl <= m_hl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // final sum; upper cross terms only reach bits 63:32
  assign cross_sum = p_lh + p_hl;
  assign product   = p_ll + {cross_sum, 32'd0};

endmodule

`default_nettype wire

FILE: rtl/core/jstr_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Decoder and register file: one request byte per go cycle, result formed
// combinationally from the registered request and the machine state.
module jstr_core #(
  parameter int MAX_INSTRUCTIONS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           go,
  input  wire jstr_pkg::req_t req,
  output jstr_pkg::res_t      res
);

  logic [63:0]                fetch_pointer, fetch_pointer_next;
  logic [63:0]                acc, acc_next;
  logic [63:0]                factor, factor_next;
  jstr_pkg::phase_t           phase, phase_next;
  logic [7:0]                 pend_op, pend_op_next;
  logic [63:0]                imm, imm_next;
  logic [3:0]                 left, left_next;
  logic [jstr_pkg::CNT_W-1:0] count, count_next;
  logic                       first, first_next;

  logic                       mul_start;
  logic                       mul_done;
  logic [63:0]                mul_product;

  jstr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (acc),
    .b       (factor),
    .done    (mul_done),
    .product (mul_product)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_pointer <= '0;
      acc           <= '0;
      factor        <= '0;
      phase         <= jstr_pkg::PH_IDLE;
      pend_op       <= '0;
      imm           <= '0;
      left          <= '0;
      count         <= '0;
      first         <= 1'b1;
    end else begin
      fetch_pointer <= fetch_pointer_next;
      acc           <= acc_next;
      factor        <= factor_next;
      phase         <= phase_next;
      pend_op       <= pend_op_next;
      imm           <= imm_next;
      left          <= left_next;
      count         <= count_next;
      first         <= first_next;
    end
  end

  // decode and execute
  always_comb begin
    logic [7:0]                 b;
    jstr_pkg::phase_t           ph;
    logic [63:0]                fp_base;
    logic                       first_c;
    logic [jstr_pkg::CNT_W-1:0] count_c;
    logic [jstr_pkg::CNT_W-1:0] count_inc;
    logic [63:0]                acc_c;
    logic [63:0]                imm_sh;
    logic [63:0]                sext;
    logic [3:0]                 left_dec;
    logic                       rej;
    logic                       resolved;
    logic                       fin;
    logic                       idle_hit;

    b        = req.code_byte;
    ph       = phase;
    fp_base  = fetch_pointer;
    first_c  = first;
    count_c  = count;
    acc_c    = acc;
    rej      = 1'b0;
    resolved = 1'b0;
    fin      = 1'b0;
    idle_hit = 1'b0;
    mul_start = 1'b0;

    imm_sh   = {b, imm[63:8]};
    sext     = {{32{imm_sh[63]}}, imm_sh[63:32]};
    left_dec = (left != 4'd0) ? left - 4'd1 : 4'd0;

    fetch_pointer_next = fetch_pointer;
    acc_next           = mul_done ? mul_product : acc;
    factor_next        = factor;
    phase_next         = phase;
    pend_op_next       = pend_op;
    imm_next           = imm;
    left_next          = left;
    count_next         = count;
    first_next         = first;

    if (go) begin
      // begin clears the machine and restarts at the request address
      if (req.begin_req) begin
        acc_next           = '0;
        factor_next        = '0;
        pend_op_next       = '0;
        imm_next           = '0;
        left_next          = '0;
        count_next         = '0;
        first_next         = 1'b1;
        fetch_pointer_next = req.byte_address;
        phase_next         = jstr_pkg::PH_OP1;
        ph                 = jstr_pkg::PH_OP1;
        fp_base            = req.byte_address;
        first_c            = 1'b1;
        count_c            = '0;
        acc_c              = '0;
      end

      if (req.begin_req && !req.committed) begin
        rej = 1'b1;
      end else if (!req.begin_req && phase == jstr_pkg::PH_IDLE) begin
        idle_hit = 1'b1;
      end else begin
        fetch_pointer_next = fp_base + 64'd1;
        unique case (ph)
          jstr_pkg::PH_OP1: begin
            if (first_c && b != jstr_pkg::OP_REX_W && b != jstr_pkg::OP_REX_WB) begin
              rej = 1'b1;
            end else if (b == jstr_pkg::OP_REX_W) begin
              phase_next = jstr_pkg::PH_OP48;
            end else if (b == jstr_pkg::OP_REX_WB) begin
              phase_next = jstr_pkg::PH_OP49;
            end else if (b == jstr_pkg::OP_GRP5) begin
              phase_next = jstr_pkg::PH_JMPRAX;
            end else if (b == jstr_pkg::OP_JMP_REL) begin
              pend_op_next = b;
              imm_next     = '0;
              left_next    = 4'd4;
              phase_next   = jstr_pkg::PH_IMM;
            end else begin
              rej = 1'b1;
            end
          end
          jstr_pkg::PH_OP48: begin
            if (first_c && b != jstr_pkg::OP_MOV_RAX) begin
              rej = 1'b1;
            end else if (b == jstr_pkg::OP_MOV_RAX) begin
              pend_op_next = b;
              imm_next     = '0;
              left_next    = 4'd8;
              phase_next   = jstr_pkg::PH_IMM;
            end else if (b == jstr_pkg::OP_ADD_RAX || b == jstr_pkg::OP_SUB_RAX ||
                         b == jstr_pkg::OP_XOR_RAX) begin
              pend_op_next = b;
              imm_next     = '0;
              left_next    = 4'd4;
              phase_next   = jstr_pkg::PH_IMM;
            end else begin
              rej = 1'b1;
            end
          end
          jstr_pkg::PH_OP49: begin
            if (first_c && b != jstr_pkg::OP_MOV_R10) begin
              rej = 1'b1;
            end else if (b == jstr_pkg::OP_ESC) begin
              phase_next = jstr_pkg::PH_IMUL_AF;
            end else if (b == jstr_pkg::OP_MOV_R10) begin
              pend_op_next = b;
              imm_next     = '0;
              left_next    = 4'd8;
              phase_next   = jstr_pkg::PH_IMM;
            end else begin
              rej = 1'b1;
            end
          end
          jstr_pkg::PH_IMUL_AF: begin
            if (b != jstr_pkg::OP_IMUL) begin
              rej = 1'b1;
            end else begin
              phase_next = jstr_pkg::PH_IMUL_C2;
            end
          end
          jstr_pkg::PH_IMUL_C2: begin
            // product passes through the multiplier registers into rax; rax is not read before then
            if (b != jstr_pkg::MODRM_C2) begin
              rej = 1'b1;
            end else begin
              mul_start = 1'b1;
              fin       = 1'b1;
            end
          end
          jstr_pkg::PH_JMPRAX: begin
            phase_next = jstr_pkg::PH_IDLE;
            if (b == jstr_pkg::MODRM_E0 && acc_c != 64'd0) begin
              resolved = 1'b1;
            end else begin
              rej = 1'b1;
            end
          end
          jstr_pkg::PH_IMM: begin
            imm_next  = imm_sh;
            left_next = left_dec;
            if (left_dec == 4'd0) begin
              fin = 1'b1;
              case (pend_op)
                jstr_pkg::OP_MOV_RAX: acc_next    = imm_sh;
                jstr_pkg::OP_MOV_R10: factor_next = imm_sh;
                jstr_pkg::OP_ADD_RAX: acc_next    = acc_c + sext;
                jstr_pkg::OP_SUB_RAX: acc_next    = acc_c - sext;
                jstr_pkg::OP_XOR_RAX: acc_next    = acc_c ^ sext;
                jstr_pkg::OP_JMP_REL: fetch_pointer_next = fp_base + sext + 64'd1;
                default: begin
                  fin = 1'b0;
                  rej = 1'b1;
                end
              endcase
            end
          end
          default: rej = 1'b1;
        endcase
      end
    end

    // instruction completion and limit check
    count_inc = count_c + 1'b1;
    if (fin && !rej) begin
      count_next = count_inc;
      first_next = 1'b0;
      phase_next = jstr_pkg::PH_OP1;
      if (count_inc >= jstr_pkg::CNT_W'(MAX_INSTRUCTIONS)) begin
        rej = 1'b1;
      end
    end

    // result
    res.status       = jstr_pkg::ST_NEED;
    res.next_address = fetch_pointer_next;
    res.target       = '0;
    if (rej) begin
      phase_next       = jstr_pkg::PH_IDLE;
      res.status       = jstr_pkg::ST_REJECT;
      res.next_address = '0;
    end else if (idle_hit) begin
      res.status       = jstr_pkg::ST_IDLE;
      res.next_address = '0;
    end else if (resolved) begin
      res.status       = jstr_pkg::ST_DONE;
      res.next_address = '0;
      res.target       = acc_c;
    end
  end

endmodule

`default_nettype wire
